@@ hw/rtl/rff_pkg.sv @@
// ----------------------------------------------------------------------------
// rff_pkg
// Shared types and constants for the rgb frame flipper.
// ----------------------------------------------------------------------------
`default_nettype none

package rff_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_COLUMNS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_ROWS    = 2'd3;

    localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 7'd64;

    // request action codes
    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    localparam int PIXEL_W = 24;

    typedef struct packed {
        logic       action;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // take the request, normalize load counters
        logic calc;      // address and frame size products
        logic store;     // write pixel, advance load counters
        logic fetch;     // read pixel, advance read index
        logic present;   // move fetched pixel into output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic out_full;  // output register holds a result that is stalled
    } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/rgb_frame_flipper_core.sv @@
// ----------------------------------------------------------------------------
// rgb_frame_flipper_core
// Mirrors an rgb frame through a frame store: load requests write each pixel
// at its flipped position, read requests stream the store out in raster order.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ------------------------------
//  in        to core    in_valid / in_stall    in_item_t  (action, rgb)
//  out       from core  out_valid / out_stall  out_item_t (rgb, frame_end)
//  cfg       to core    cfg_write              cfg_index, cfg_data
//
//  a load request goes through accept, address multiply-add and store write
//  a read request goes through accept, frame size multiply, store read and
//  output load, which waits while the output register stays stalled
//  one request at a time is sequenced through the frame store write and read ports
//  the output register lets a new request enter while a result waits
//  reset clears counters, config and control; frame store content is kept
//
`default_nettype none

module rgb_frame_flipper_core
    import rff_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // request input
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_item_t               in_data,
    // result output
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_item_t                   out_data
);

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: idle, address, memory access, output hand-off
    rff_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, mirror math, frame store and output register
    rff_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // an accepted request keeps the input stalled in the next cycle
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input not stalled after accepting a request");

    // a store read is followed by the output hand-off state, still busy
    a_busy_after_fetch: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.fetch |=> (in_stall && !cmd.fetch && !cmd.store)
    ) else $error("sequencer left the read hand-off early");

    // a new result appears only from an output load
    a_result_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.present)
    ) else $error("result raised without an output load");

    // store writes and reads never overlap
    a_port_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.store |-> (!cmd.fetch && !cmd.present && !cmd.capture)
    ) else $error("frame store write overlaps other commands");

endmodule

`default_nettype wire

@@ hw/rtl/rff_ram.sv @@
// ----------------------------------------------------------------------------
// rff_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rff_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rff_ctrl.sv @@
// ----------------------------------------------------------------------------
// rff_ctrl
// Sequencer: one request at a time through capture, address, memory, and for reads output.
// ----------------------------------------------------------------------------
`default_nettype none

module rff_ctrl
    import rff_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADDR = 2'd1;
    localparam logic [1:0] S_MEM  = 2'd2;
    localparam logic [1:0] S_DATA = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_ADDR;
                end
            end
            S_ADDR:
            begin
                cmd.calc   = 1'b1;
                state_next = S_MEM;
            end
            S_MEM:
            begin
                if (status.is_read)
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_DATA;
                end
                else
                begin
                    cmd.store  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DATA:
            begin
                // wait for room in the output register
                if (!status.out_full)
                begin
                    cmd.present = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/rff_datapath.sv @@
// ----------------------------------------------------------------------------
// rff_datapath
// Config registers, load and read counters, address math, frame store, output.
// ----------------------------------------------------------------------------
`default_nettype none

module rff_datapath
    import rff_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire in_item_t               in_data,
    input  wire cmd_t                   cmd,
    output status_t                     status,
    input  wire logic                   out_stall,
    output logic                        out_valid,
    output out_item_t                   out_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int TW    = WW + HW;

    // configuration
    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;
    logic                  mirror_columns_reg;
    logic                  mirror_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= SIZE_RESET;
            frame_height_reg   <= SIZE_RESET;
            mirror_columns_reg <= 1'b0;
            mirror_rows_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_data;
                CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data;
                CFG_MIRROR_COLUMNS: mirror_columns_reg <= cfg_data[0];
                CFG_MIRROR_ROWS:    mirror_rows_reg    <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // effective frame size, zero acts as one, large values clamp
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = WW'(1);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(frame_width_reg);

        if (frame_height_reg == '0)
            h_eff = HW'(1);
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(frame_height_reg);
    end

    // counters
    logic [CW-1:0] load_col_reg, load_col_next;
    logic [RW-1:0] load_row_reg, load_row_next;
    logic [AW-1:0] read_idx_reg, read_idx_next;

    // per request registers
    logic                 action_reg;
    logic [PIXEL_W-1:0]   pix_reg;
    logic [CW-1:0]        col_norm_reg;
    logic [RW-1:0]        row_norm_reg;
    logic [CW-1:0]        col_mir_reg;
    logic [RW-1:0]        row_mir_reg;
    logic [AW-1:0]        addr_reg;
    logic [TW-1:0]        total_reg;
    logic                 last_reg;

    // normalize load counters and mirror them
    logic [CW-1:0] col_norm, col_mir;
    logic [RW-1:0] row_norm, row_mir;

    always_comb
    begin
        col_norm = (WW'(load_col_reg) >= w_eff) ? '0 : load_col_reg;
        row_norm = (HW'(load_row_reg) >= h_eff) ? '0 : load_row_reg;
        col_mir  = mirror_columns_reg ? CW'(w_eff - WW'(1) - WW'(col_norm)) : col_norm;
        row_mir  = mirror_rows_reg ? RW'(h_eff - HW'(1) - HW'(row_norm)) : row_norm;
    end

    // entry address and frame size
    logic [RW+WW-1:0] addr_full;
    logic [TW-1:0]    total_full;

    assign addr_full  = (RW+WW)'(row_mir_reg) * (RW+WW)'(w_eff) + (RW+WW)'(col_mir_reg);
    assign total_full = TW'(w_eff) * TW'(h_eff);

    // read index handling
    logic [AW-1:0] rd_idx;
    logic          rd_last;

    always_comb
    begin
        rd_idx  = (TW'(read_idx_reg) >= total_reg) ? '0 : read_idx_reg;
        rd_last = (TW'(rd_idx) == (total_reg - TW'(1)));
    end

    // next load position
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;

    always_comb
    begin
        col_inc       = WW'(col_norm_reg) + WW'(1);
        row_inc       = HW'(row_norm_reg) + HW'(1);
        load_col_next = load_col_reg;
        load_row_next = load_row_reg;
        read_idx_next = read_idx_reg;
        if (cmd.store)
        begin
            if (col_inc >= w_eff)
            begin
                load_col_next = '0;
                load_row_next = (row_inc >= h_eff) ? '0 : RW'(row_inc);
            end
            else
            begin
                load_col_next = CW'(col_inc);
                load_row_next = row_norm_reg;
            end
        end
        if (cmd.fetch)
        begin
            read_idx_next = rd_last ? '0 : rd_idx + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_col_reg <= '0;
            load_row_reg <= '0;
            read_idx_reg <= '0;
        end
        else
        begin
            load_col_reg <= load_col_next;
            load_row_reg <= load_row_next;
            read_idx_reg <= read_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg   <= in_data.action;
            pix_reg      <= {in_data.red_in, in_data.green_in, in_data.blue_in};
            col_norm_reg <= col_norm;
            row_norm_reg <= row_norm;
            col_mir_reg  <= col_mir;
            row_mir_reg  <= row_mir;
        end
        if (cmd.calc)
        begin
            addr_reg  <= AW'(addr_full);
            total_reg <= total_full;
        end
        if (cmd.fetch)
        begin
            last_reg <= rd_last;
        end
    end

    // frame store
    logic [PIXEL_W-1:0] rd_pix;

    rff_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (addr_reg),
        .wdata (pix_reg),
        .re    (cmd.fetch),
        .raddr (rd_idx),
        .rdata (rd_pix)
    );

    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg;

    always_comb
    begin
        if (cmd.present)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.present)
        begin
            out_reg.red_out   <= rd_pix[23:16];
            out_reg.green_out <= rd_pix[15:8];
            out_reg.blue_out  <= rd_pix[7:0];
            out_reg.frame_end <= last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;
    assign status.is_read  = (action_reg == ACTION_READ);
    assign status.out_full = out_valid_reg && out_stall;

endmodule

`default_nettype wire

@@ verif/tb_rgb_frame_flipper_core.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_frame_flipper_core
// Self-checking bench for the rgb frame flipper. A queue-fed driver sends load
// and read requests. A shadow frame store predicts every pixel that a read
// returns. The run covers the reset frame size, small and out-of-range sizes,
// and the mirror flags in directed and random combinations.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rgb_frame_flipper_core;
    import rff_pkg::*;

    localparam int FRAME_MAX     = 64;
    localparam int STORE_DEPTH   = FRAME_MAX * FRAME_MAX;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_REQS   = 280;

    // one request waiting in the driver queue, with its lead-in gap
    typedef struct packed {
        in_item_t   req;
        logic [2:0] gap;
        logic       drain;  // hold until every pending pixel has come back
    } queued_req_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;

    rgb_frame_flipper_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // shadow of the block: frame store, counters and registers
    // ------------------------------------------------------------------
    logic [23:0]   pixel_mem [STORE_DEPTH];
    int unsigned   load_col;
    int unsigned   load_row;
    int unsigned   read_pos;
    logic [6:0]    width_reg;
    logic [6:0]    height_reg;
    logic          mirror_col_reg;
    logic          mirror_row_reg;

    queued_req_t   req_queue [$];   // requests not yet presented
    out_item_t     due_pixels [$];  // pixels that reads still owe us

    logic          in_took      = 1'b0;
    logic          out_took     = 1'b0;
    logic          sender_quiet = 1'b0;
    logic          out_calm     = 1'b0;
    int unsigned   gap_count    = 0;
    int unsigned   stall_left   = 0;
    int unsigned   mismatches   = 0;
    int unsigned   result_count = 0;
    int unsigned   cycle_count  = 0;

    // size register as the block uses it: zero acts as one, above max clamps
    function automatic int unsigned usable_size(logic [6:0] raw);
        if (raw == 7'd0)
            return 1;
        if (raw > FRAME_MAX)
            return FRAME_MAX;
        return raw;
    endfunction

    // apply one accepted request to the shadow; reads queue their pixel
    task automatic mirror_request(input in_item_t req);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned col;
        int unsigned row;
        out_item_t   pix;
        w     = usable_size(width_reg);
        h     = usable_size(height_reg);
        total = w * h;
        if (req.action == ACTION_LOAD) begin
            // a size change may leave the load position outside the frame
            if (load_col >= w)
                load_col = 0;
            if (load_row >= h)
                load_row = 0;
            col = mirror_col_reg ? (w - 1 - load_col) : load_col;
            row = mirror_row_reg ? (h - 1 - load_row) : load_row;
            pixel_mem[row * w + col] = {req.red_in, req.green_in, req.blue_in};
            load_col++;
            if (load_col >= w) begin
                load_col = 0;
                load_row++;
                if (load_row >= h)
                    load_row = 0;
            end
        end
        else begin
            if (read_pos >= total)
                read_pos = 0;
            pix = '0;
            {pix.red_out, pix.green_out, pix.blue_out} = pixel_mem[read_pos];
            pix.frame_end = (read_pos == total - 1);
            due_pixels.push_back(pix);
            read_pos = pix.frame_end ? 0 : read_pos + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // rising edge: check returned pixels first, then predict new requests
    // ------------------------------------------------------------------
    always @(posedge clk) begin : scoreboard
        out_item_t want;
        if (rst_n) begin
            if (out_valid === 1'b1 && out_stall === 1'b0) begin
                result_count++;
                if (due_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel %0d: none expected, got rgb %h %h %h end %b",
                                 result_count, out_data.red_out, out_data.green_out,
                                 out_data.blue_out, out_data.frame_end);
                end
                else begin
                    want = due_pixels.pop_front();
                    if (out_data.red_out !== want.red_out
                        || out_data.green_out !== want.green_out
                        || out_data.blue_out !== want.blue_out
                        || out_data.frame_end !== want.frame_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"pixel %0d: expected rgb %h %h %h end %b,",
                                      " got rgb %h %h %h end %b"},
                                     result_count, want.red_out, want.green_out,
                                     want.blue_out, want.frame_end, out_data.red_out,
                                     out_data.green_out, out_data.blue_out,
                                     out_data.frame_end);
                    end
                end
            end
            if (in_valid && in_stall === 1'b0)
                mirror_request(in_data);
            in_took  <= in_valid && in_stall === 1'b0;
            out_took <= out_valid === 1'b1 && out_stall === 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // request driver: falling edge, one request at a time from the queue
    // ------------------------------------------------------------------
    always @(negedge clk) begin : request_driver
        logic hold;
        if (rst_n) begin
            // a stalled request stays up with its payload untouched
            hold = in_valid && !in_took;
            if (!hold && req_queue.size() != 0) begin
                // a drain request waits for all outstanding pixels
                if (!(req_queue[0].drain && due_pixels.size() != 0)) begin
                    if (gap_count < req_queue[0].gap)
                        gap_count++;
                    else begin
                        in_data <= req_queue[0].req;
                        void'(req_queue.pop_front());
                        gap_count = 0;
                        hold      = 1'b1;
                    end
                end
            end
            in_valid <= hold;
        end
    end

    // ------------------------------------------------------------------
    // result side: stall pixels at random, with calm stretches
    // ------------------------------------------------------------------
    always @(negedge clk) begin : result_stall
        if (rst_n) begin
            if (out_took) begin
                if ($urandom_range(0, 31) == 0)
                    out_calm = !out_calm;
                stall_left = out_calm ? 0 : $urandom_range(0, 4);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                if (out_valid === 1'b1)
                    stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rgb_frame_flipper_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_req(input logic action, input logic [23:0] rgb,
                             input logic drain);
        queued_req_t q;
        q.req.action = action;
        {q.req.red_in, q.req.green_in, q.req.blue_in} = rgb;
        q.gap   = sender_quiet ? 3'd0 : 3'($urandom_range(0, 4));
        q.drain = drain;
        req_queue.push_back(q);
    endtask

    // wait for the block to go idle: no request left, no pixel owed
    task automatic settle();
        @(negedge clk);
        while (req_queue.size() != 0 || in_valid || due_pixels.size() != 0)
            @(negedge clk);
        // trailing loads produce no pixel, give them time to finish
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_FRAME_WIDTH:    width_reg      = val;
            CFG_FRAME_HEIGHT:   height_reg     = val;
            CFG_MIRROR_COLUMNS: mirror_col_reg = val[0];
            CFG_MIRROR_ROWS:    mirror_row_reg = val[0];
            default: ;
        endcase
    endtask

    // program a frame while idle, then hand back at a rising edge
    task automatic set_frame(input logic [6:0] w, input logic [6:0] h,
                             input logic mc, input logic mr);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_MIRROR_COLUMNS, {6'd0, mc});
        write_reg(CFG_MIRROR_ROWS, {6'd0, mr});
        @(negedge clk);
        cfg_write <= 1'b0;
        sender_quiet = ($urandom_range(0, 3) == 0);
        @(posedge clk);
    endtask

    // mostly small frames, sometimes full size or out of range
    function automatic logic [6:0] pick_size();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 7'd0;
        if (sel == 1)
            return 7'($urandom_range(65, 127));
        if (sel == 2)
            return 7'd64;
        if (sel <= 5)
            return 7'($urandom_range(9, 63));
        return 7'($urandom_range(1, 8));
    endfunction

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned i;
        int unsigned n;
        int unsigned total;
        int unsigned drain_at;
        int unsigned random_reqs;
        int unsigned filled;        // entries 0 .. filled-1 hold a loaded pixel
        logic [6:0]  w_raw;
        logic [6:0]  h_raw;
        width_reg      = SIZE_RESET;
        height_reg     = SIZE_RESET;
        mirror_col_reg = 1'b0;
        mirror_row_reg = 1'b0;
        load_col       = 0;
        load_row       = 0;
        read_pos       = 0;
        random_reqs    = 0;
        filled         = 0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // reset settings (64 x 64, no flip): the first row is partly loaded
        // and read back no further than it was written
        @(posedge clk);
        for (i = 0; i < 40; i++)
            queue_req(ACTION_LOAD, 24'($urandom), 1'b0);
        for (i = 0; i < 32; i++)
            queue_req(ACTION_READ, 24'($urandom), 1'b0);
        filled = 40;
        settle();

        // 2 x 2, both flips; the fifth load wraps onto the first position
        set_frame(7'd2, 7'd2, 1'b1, 1'b1);
        queue_req(ACTION_LOAD, 24'h000000, 1'b0);
        queue_req(ACTION_LOAD, 24'hffffff, 1'b0);
        queue_req(ACTION_LOAD, 24'haa55aa, 1'b0);
        queue_req(ACTION_LOAD, 24'h55aa55, 1'b0);
        queue_req(ACTION_LOAD, 24'h0f0f0f, 1'b0);
        for (i = 0; i < 5; i++)
            queue_req(ACTION_READ, 24'($urandom), i == 2);
        settle();

        // zero sizes act as 1 x 1; load column and read index now sit beyond the frame
        set_frame(7'd0, 7'd0, 1'b0, 1'b0);
        queue_req(ACTION_LOAD, 24'hffffff, 1'b0);
        queue_req(ACTION_READ, 24'hffffff, 1'b0);
        queue_req(ACTION_READ, 24'h000000, 1'b0);
        settle();

        // single column, rows reversed
        set_frame(7'd1, 7'd3, 1'b0, 1'b1);
        queue_req(ACTION_LOAD, 24'h123456, 1'b0);
        queue_req(ACTION_LOAD, 24'h89abcd, 1'b0);
        queue_req(ACTION_LOAD, 24'hfedcba, 1'b0);
        for (i = 0; i < 3; i++)
            queue_req(ACTION_READ, 24'($urandom), 1'b0);
        settle();

        // oversize width clamps to 64, zero height acts as 1; flipped round trip
        set_frame(7'd127, 7'd0, 1'b1, 1'b1);
        for (i = 0; i < FRAME_MAX; i++)
            queue_req(ACTION_LOAD, 24'($urandom), 1'b0);
        for (i = 0; i < FRAME_MAX; i++)
            queue_req(ACTION_READ, 24'($urandom), 1'b0);
        filled = FRAME_MAX;
        settle();

        // random phases, each under a fresh frame setting
        while (random_reqs < RANDOM_REQS) begin
            // a frame either fits a full load or lies inside loaded entries
            do begin
                w_raw = pick_size();
                h_raw = pick_size();
                total = usable_size(w_raw) * usable_size(h_raw);
            end while (total > 48 && total > filled);
            set_frame(w_raw, h_raw, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (total > filled || $urandom_range(0, 2) != 0) begin
                // whole frame in, then the frame read back out
                n        = total + $urandom_range(0, 3);
                drain_at = $urandom_range(0, 2 * n);
                for (i = 0; i < total; i++)
                    queue_req(ACTION_LOAD, 24'($urandom), 1'b0);
                for (i = 0; i < n; i++)
                    queue_req(ACTION_READ, 24'($urandom), i == drain_at);
                random_reqs += total + n;
                if (total > filled)
                    filled = total;
            end
            else begin
                // loads and reads mixed at random
                n        = $urandom_range(20, 60);
                drain_at = $urandom_range(0, 4 * n);
                for (i = 0; i < n; i++)
                    queue_req(1'($urandom_range(0, 1)), 24'($urandom), i == drain_at);
                random_reqs += n;
            end
            settle();
        end

        if (mismatches == 0)
            $display("rgb_frame_flipper_core: match");
        else
            $display("rgb_frame_flipper_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/rff_pkg.sv
hw/rtl/rff_ram.sv
hw/rtl/rff_ctrl.sv
hw/rtl/rff_datapath.sv
hw/rtl/rgb_frame_flipper_core.sv
verif/tb_rgb_frame_flipper_core.sv
